// ===== rtl/core/psbe_pkg.sv =====
// ----------------------------------------------------------------------------
// psbe_pkg: shared definitions for the pixel set boundary edges unit
// Default sizes and the command and status groups that join the controller
// and the datapath.
// ----------------------------------------------------------------------------
package psbe_pkg;

  // default store depth and coordinate width
  localparam int MAX_PIXELS_DEF = 64;
  localparam int COORD_BITS_DEF = 12;

  // commands from the controller to the datapath
  typedef struct packed {
    logic store;   // write the incoming pixel, or flag overflow when full
    logic emit;    // produce one result and rotate the store ring
    logic clear;   // end of set: empty the store and reset the counters
  } psbe_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
    logic last_one;  // the pixel at the head of the ring is the last of the set
  } psbe_status_t;

endpackage

// ===== rtl/core/pixel_set_boundary_edges_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_set_boundary_edges_unit: four-neighbour boundary detection of a set
// Loads a set of pixels and reports, per pixel, which neighbours are missing.
// ----------------------------------------------------------------------------
// Pixels arrive on the slave stream, one per item, and each loads into a store
// of MAX_PIXELS registers. The item with tlast set closes the set; from then
// on the input is not ready while the unit emits one result per stored pixel,
// in load order, at one result per cycle as long as the master side takes
// them: the head entry of the store ring is compared with all valid entries
// at once and the ring rotates by one. Pixels beyond the store depth are
// dropped and flagged in every result of the set. After the last result the
// store is empty and a new set may load at once.
module pixel_set_boundary_edges_unit
  import psbe_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int TOT_W     = $clog2(4 * MAX_PIXELS + 1),
  localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_RAW_W = 2 * COORD_BITS + 4 + TOT_W + 1,
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // pixel_x, pixel_y
  input  logic             s_tlast,   // final_pixel
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // out_x, out_y, open_sides, edge_total, dropped
  output logic             m_tlast    // final_result
);

  psbe_cmd_t                    cmd;
  psbe_status_t                 status;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic [3:0]                   open_sides;
  logic [TOT_W-1:0]             edge_total;
  logic                         dropped;

  // unpack the input item
  assign pixel_x = s_tdata[COORD_BITS-1:0];
  assign pixel_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

  psbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  psbe_datapath #(
    .MAX_PIXELS (MAX_PIXELS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_x        (out_x),
    .out_y        (out_y),
    .open_sides   (open_sides),
    .edge_total   (edge_total),
    .dropped      (dropped),
    .final_result (m_tlast)
  );

  // pack the result item, zero filled to whole bytes
  assign m_tdata = OUT_W'({dropped, edge_total, open_sides, out_y, out_x});

endmodule

// ===== rtl/core/psbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// psbe_ctrl: sequencer of the pixel set boundary edges unit
// Loads pixels until the item marked last, then steps the emission of one
// result per stored pixel.
// ----------------------------------------------------------------------------
module psbe_ctrl
  import psbe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_last,
  output logic         in_ready,
  input  psbe_status_t status,
  output psbe_cmd_t    cmd
);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_one) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/psbe_datapath.sv =====
// ----------------------------------------------------------------------------
// psbe_datapath: pixel store ring, neighbour match and result register
// Pixels sit in a ring of registers with one valid bit each. The head entry is
// tested against every valid entry in parallel for its four neighbours; the
// ring then rotates by one so the next pixel in load order reaches the head.
// ----------------------------------------------------------------------------
module psbe_datapath
  import psbe_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CNT_W     = $clog2(MAX_PIXELS + 1),
  localparam int TOT_W     = $clog2(4 * MAX_PIXELS + 1)
)
(
  input  logic                         clk,
  input  logic                         rst,
  input  psbe_cmd_t                    cmd,
  output psbe_status_t                 status,
  input  logic signed [COORD_BITS-1:0] pixel_x,
  input  logic signed [COORD_BITS-1:0] pixel_y,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic [3:0]                   open_sides,
  output logic [TOT_W-1:0]             edge_total,
  output logic                         dropped,
  output logic                         final_result
);

  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] ent_x [MAX_PIXELS];
  logic signed [COORD_BITS-1:0] ent_y [MAX_PIXELS];
  logic [MAX_PIXELS-1:0]        valid;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             emit_idx;
  logic                         overflow;
  logic [TOT_W-1:0]             edge_acc;
  logic [TOT_W-1:0]             edge_next;
  logic                         room;

  logic signed [COORD_BITS-1:0] head_x;
  logic signed [COORD_BITS-1:0] head_y;
  logic signed [COORD_BITS-1:0] xp1;
  logic signed [COORD_BITS-1:0] xm1;
  logic signed [COORD_BITS-1:0] yp1;
  logic signed [COORD_BITS-1:0] ym1;
  logic [MAX_PIXELS-1:0]        hit_r;
  logic [MAX_PIXELS-1:0]        hit_d;
  logic [MAX_PIXELS-1:0]        hit_l;
  logic [MAX_PIXELS-1:0]        hit_u;
  logic [3:0]                   sides;

  assign room   = (count < CNT_W'(MAX_PIXELS));
  assign head_x = ent_x[0];
  assign head_y = ent_y[0];
  assign xp1    = head_x + COORD_BITS'(1);
  assign xm1    = head_x - COORD_BITS'(1);
  assign yp1    = head_y + COORD_BITS'(1);
  assign ym1    = head_y - COORD_BITS'(1);

  // parallel neighbour match against every valid entry
  for (genvar k = 0; k < MAX_PIXELS; k++) begin : g_match
    assign hit_r[k] = valid[k] && (ent_x[k] == xp1) && (ent_y[k] == head_y);
    assign hit_d[k] = valid[k] && (ent_x[k] == head_x) && (ent_y[k] == ym1);
    assign hit_l[k] = valid[k] && (ent_x[k] == xm1) && (ent_y[k] == head_y);
    assign hit_u[k] = valid[k] && (ent_x[k] == head_x) && (ent_y[k] == yp1);
  end

  // a neighbour past the edge of the coordinate range is always absent
  assign sides[0] = !((head_x != CMAX) && (|hit_r));
  assign sides[1] = !((head_y != CMIN) && (|hit_d));
  assign sides[2] = !((head_x != CMIN) && (|hit_l));
  assign sides[3] = !((head_y != CMAX) && (|hit_u));

  assign edge_next = edge_acc + TOT_W'(sides[0]) + TOT_W'(sides[1])
                   + TOT_W'(sides[2]) + TOT_W'(sides[3]);

  assign status.out_free = !out_valid || out_ready;
  assign status.last_one = ((emit_idx + CNT_W'(1)) == count);

  // store ring: indexed write on load, rotate by one on each result
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PIXELS; k++) begin
      if (cmd.store && room && (count == CNT_W'(k))) begin
        ent_x[k] <= pixel_x;
        ent_y[k] <= pixel_y;
      end else if (cmd.emit) begin
        ent_x[k] <= ent_x[(k + 1) % MAX_PIXELS];
        ent_y[k] <= ent_y[(k + 1) % MAX_PIXELS];
      end
    end
  end

  // valid bits, counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      count    <= '0;
      emit_idx <= '0;
      overflow <= 1'b0;
      edge_acc <= '0;
    end else if (cmd.clear) begin
      valid    <= '0;
      count    <= '0;
      emit_idx <= '0;
      overflow <= 1'b0;
      edge_acc <= '0;
    end else begin
      if (cmd.store) begin
        if (room) begin
          for (int k = 0; k < MAX_PIXELS; k++) begin
            if (count == CNT_W'(k)) begin
              valid[k] <= 1'b1;
            end
          end
          count <= count + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.emit) begin
        for (int k = 0; k < MAX_PIXELS; k++) begin
          valid[k] <= valid[(k + 1) % MAX_PIXELS];
        end
        emit_idx <= emit_idx + CNT_W'(1);
        edge_acc <= edge_next;
      end
    end
  end

  // output register handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x        <= head_x;
      out_y        <= head_y;
      open_sides   <= sides;
      edge_total   <= edge_next;
      dropped      <= overflow;
      final_result <= status.last_one;
    end
  end

endmodule

// ===== tb/sv/pixel_set_boundary_edges_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_set_boundary_edges_unit_tb: self-checking bench for the boundary unit
// Streams pixel sets into the unit and predicts every per-pixel report: the
// mask of missing four-neighbours, the running edge total, the drop flag and
// the end-of-set mark. Covers coordinate extremes without wrap, duplicates,
// a full store, overflow and random clusters under varying back-pressure.
// ----------------------------------------------------------------------------
module pixel_set_boundary_edges_unit_tb;
  import psbe_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int NPIX        = MAX_PIXELS_DEF;
  localparam int TW          = $clog2(4 * NPIX + 1);
  localparam int IN_W        = ((2 * CW + 7) / 8) * 8;
  localparam int OUT_W       = ((2 * CW + 4 + TW + 1 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 40;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
  } pixel_t;

  typedef struct {
    coord_t          x;
    coord_t          y;
    logic [3:0]      sides;
    logic [TW-1:0]   total;
    logic            dropped;
    logic            last;
  } edge_report_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;   // pixel_x, pixel_y
  logic             s_tlast;   // final_pixel
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;   // out_x, out_y, open_sides, edge_total, dropped
  logic             m_tlast;   // final_result

  // model state and pending reports
  pixel_t       loaded_pixels[$];
  bit           overflow_flag;
  edge_report_t expected_reports[$];

  int idle_pct;
  int stall_pct;
  int mismatch_count;
  int cycle_count;

  pixel_set_boundary_edges_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic bit pixel_present(int x, int y);
    foreach (loaded_pixels[i]) begin
      if (int'(loaded_pixels[i].x) == x && int'(loaded_pixels[i].y) == y) return 1'b1;
    end
    return 1'b0;
  endfunction

  // store one pixel; on the set's last pixel, queue one report per stored pixel
  function automatic void predict_boundary(coord_t x, coord_t y, bit fin);
    edge_report_t  r;
    pixel_t        p;
    int            px;
    int            py;
    logic [TW-1:0] running;
    p.x = x;
    p.y = y;
    if (loaded_pixels.size() < NPIX) loaded_pixels = {loaded_pixels, p};
    else overflow_flag = 1'b1;
    if (!fin) return;
    running = '0;
    foreach (loaded_pixels[i]) begin
      px = loaded_pixels[i].x;
      py = loaded_pixels[i].y;
      // neighbours are formed in plain integers, so nothing wraps at the range edge
      r.sides[0] = !pixel_present(px + 1, py);
      r.sides[1] = !pixel_present(px, py - 1);
      r.sides[2] = !pixel_present(px - 1, py);
      r.sides[3] = !pixel_present(px, py + 1);
      running = running + r.sides[0] + r.sides[1] + r.sides[2] + r.sides[3];
      r.x       = loaded_pixels[i].x;
      r.y       = loaded_pixels[i].y;
      r.total   = running;
      r.dropped = overflow_flag;
      r.last    = (i == loaded_pixels.size() - 1);
      expected_reports = {expected_reports, r};
    end
    loaded_pixels.delete();
    overflow_flag = 1'b0;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, want,
               cycle_count);
  endtask

  // result side: check accepted items, then pick the next tready
  initial begin
    edge_report_t     e;
    logic [OUT_W-1:0] d;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        d = m_tdata;
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected result", d, '0);
        end else begin
          e = expected_reports.pop_front();
          if (d[CW-1:0] !== e.x) report_mismatch("out_x", d[CW-1:0], e.x);
          if (d[2*CW-1:CW] !== e.y) report_mismatch("out_y", d[2*CW-1:CW], e.y);
          if (d[2*CW+3:2*CW] !== e.sides)
            report_mismatch("open_sides", d[2*CW+3:2*CW], e.sides);
          if (d[2*CW+4+TW-1:2*CW+4] !== e.total)
            report_mismatch("edge_total", d[2*CW+4+TW-1:2*CW+4], e.total);
          if (d[2*CW+4+TW] !== e.dropped)
            report_mismatch("dropped", d[2*CW+4+TW], e.dropped);
          if (m_tlast !== e.last) report_mismatch("final_result", m_tlast, e.last);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // send one pixel, with random idle cycles before it
  task automatic send_pixel(coord_t x, coord_t y, bit fin);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    predict_boundary(x, y, fin);
  endtask

  // one isolated pixel: all four sides open
  task automatic test_single_pixel();
    send_pixel(12'sd0, 12'sd0, 1'b1);
  endtask

  // corners of the coordinate range: no neighbour across the wrap
  task automatic test_range_extremes();
    send_pixel(12'sd2047, 12'sd2047, 1'b0);
    send_pixel(-12'sd2048, -12'sd2048, 1'b0);
    send_pixel(12'sd2047, -12'sd2048, 1'b0);
    send_pixel(-12'sd2048, 12'sd2047, 1'b0);
    send_pixel(12'sd2046, 12'sd2047, 1'b1);
  endtask

  // 2x2 block with a duplicate pixel
  task automatic test_square_duplicate();
    send_pixel(12'sd5, 12'sd5, 1'b0);
    send_pixel(12'sd6, 12'sd5, 1'b0);
    send_pixel(12'sd5, 12'sd6, 1'b0);
    send_pixel(12'sd6, 12'sd6, 1'b0);
    send_pixel(12'sd5, 12'sd5, 1'b1);
  endtask

  // plus shape: the center has every neighbour
  task automatic test_plus_shape();
    send_pixel(-12'sd100, 12'sd40, 1'b0);
    send_pixel(-12'sd99, 12'sd40, 1'b0);
    send_pixel(-12'sd100, 12'sd39, 1'b0);
    send_pixel(-12'sd101, 12'sd40, 1'b0);
    send_pixel(-12'sd100, 12'sd41, 1'b1);
  endtask

  // fill the store, then overflow it so that the set's last pixel is dropped
  task automatic test_store_capacity();
    for (int k = 0; k < NPIX + 3; k++)
      send_pixel(coord_t'(k - 30), -12'sd2048, k == NPIX + 2);
  endtask

  // random clusters, some near the range edges so coordinates wrap in the bits
  task automatic test_random_sets(int n_items);
    int     sent;
    int     size;
    int     spread;
    coord_t bx;
    coord_t by;
    sent = 0;
    while (sent < n_items) begin
      size   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
      spread = $urandom_range(1, 4);
      case ($urandom_range(0, 4))
        0:       bx = 12'sd2046;
        1:       bx = -12'sd2048;
        default: bx = coord_t'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       by = 12'sd2046;
        1:       by = -12'sd2048;
        default: by = coord_t'($urandom);
      endcase
      for (int k = 0; k < size; k++)
        send_pixel(bx + coord_t'($urandom_range(0, spread)),
                   by + coord_t'($urandom_range(0, spread)), k == size - 1);
      sent += size;
    end
  endtask

  // main sequence
  initial begin
    mismatch_count = 0;
    overflow_flag  = 1'b0;
    idle_pct       = 14;
    stall_pct      = 63;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_pixel();
    test_range_extremes();
    test_square_duplicate();
    test_plus_shape();
    test_random_sets(20);

    idle_pct  = 63;
    stall_pct = 14;
    test_store_capacity();
    test_random_sets(20);

    idle_pct  = 0;
    stall_pct = 0;
    test_random_sets(20);

    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && loaded_pixels.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== pixel_set_boundary_edges_unit.f =====
rtl/core/psbe_pkg.sv
rtl/core/psbe_ctrl.sv
rtl/core/psbe_datapath.sv
rtl/core/pixel_set_boundary_edges_unit.sv
tb/sv/pixel_set_boundary_edges_unit_tb.sv
